### sv/itoa_pkg.sv
// Shared types, constants and a helper function for the integer-to-ASCII converter.
package itoa_pkg;

    localparam int VALUE_BITS     = 32;
    localparam int MAX_RADIX_DEF  = 32;
    localparam int RADIX_BITS     = 6;
    localparam int CHAR_BITS      = 7;
    localparam int DIGIT_MAX_BITS = 6;

    localparam logic [RADIX_BITS-1:0] MIN_RADIX = RADIX_BITS'(2);
    localparam logic [RADIX_BITS-1:0] DECIMAL   = RADIX_BITS'(10);
    localparam logic [CHAR_BITS-1:0]  DIGIT_BASE  = CHAR_BITS'(48);
    localparam logic [CHAR_BITS-1:0]  LETTER_BASE = CHAR_BITS'(65);
    localparam logic [CHAR_BITS-1:0]  CHAR_MINUS  = CHAR_BITS'(45);
    localparam logic [CHAR_BITS-1:0]  CHAR_NONE   = CHAR_BITS'(0);

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] value;
        logic [RADIX_BITS-1:0]        radix;
    } in_word_t;

    typedef struct packed {
        logic [CHAR_BITS-1:0] character;
        logic                 last_char;
        logic                 bad_radix;
    } out_word_t;

    typedef struct packed {
        logic clear;
        logic act0;
        logic feed_bit;
        logic shift;
    } digit_ctl_t;

    function automatic logic [CHAR_BITS-1:0] digit_char(input logic [DIGIT_MAX_BITS-1:0] d);
        logic [CHAR_BITS-1:0] dw;
        dw = CHAR_BITS'(d);
        if (d < DIGIT_MAX_BITS'(10)) begin
            return DIGIT_BASE + dw;
        end
        return LETTER_BASE + dw - CHAR_BITS'(10);
    endfunction

endpackage

### sv/int_to_ascii_radix.sv
// Top level of the integer-to-ASCII converter.
// Converts a signed VALUE_BITS-bit word and a radix (2 to MAX_RADIX) into ASCII characters of
// its magnitude, most significant first, one result word per character; last_char marks the
// final one, a '-' leads only for negative values in radix 10, and an invalid radix gives a
// single word with bad_radix set and character 0. One item at a time: the magnitude enters a
// row of VALUE_BITS digit cells one bit per cycle, with registered carries between the cells;
// the digit row then shifts out one cell per cycle unless a character waits on a stalled
// result side, with leading zeros dropped and any sign word sent first.
module int_to_ascii_radix
    import itoa_pkg::*;
#(
    parameter int MAX_RADIX = MAX_RADIX_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    localparam int N  = VALUE_BITS;
    localparam int CW = $clog2(2 * N);
    localparam logic [CW-1:0] CONV_LAST = CW'(2 * N - 2);
    localparam logic [CW-1:0] N_CNT     = CW'(N);
    localparam logic [CW-1:0] ONE_CNT   = CW'(1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_EMIT,
        ST_ERR
    } state_t;

    state_t                    state_reg, state_next;
    logic [N-1:0]              mag_reg, mag_next;
    logic [RADIX_BITS-1:0]     radix_reg, radix_next;
    logic                      sign_reg, sign_next;
    logic                      started_reg, started_next;
    logic [CW-1:0]             cnt_reg, cnt_next;
    logic                      m_valid_reg, m_valid_next;
    out_word_t                 m_data_reg, m_data_next;

    digit_ctl_t                ctl;
    logic [DIGIT_MAX_BITS-1:0] top_digit;
    logic                      accept;
    logic                      m_free;
    logic                      skip;
    logic                      radix_ok;
    logic                      neg;
    logic [N-1:0]              value_u;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign m_free   = !m_valid_reg || m_ready;
    assign value_u  = s_data.value;
    assign neg      = value_u[N-1];
    assign radix_ok = (s_data.radix >= MIN_RADIX) &&
                      (s_data.radix <= RADIX_BITS'(MAX_RADIX));
    assign skip     = !sign_reg && (top_digit == '0) && !started_reg && (cnt_reg > ONE_CNT);

    itoa_digit_array #(
        .MAX_RADIX(MAX_RADIX)
    ) u_digits (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (ctl),
        .radix    (radix_reg),
        .top_digit(top_digit)
    );

    always_comb begin
        state_next    = state_reg;
        mag_next      = mag_reg;
        radix_next    = radix_reg;
        sign_next     = sign_reg;
        started_next  = started_reg;
        cnt_next      = cnt_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;
        ctl.clear     = 1'b0;
        ctl.act0      = 1'b0;
        ctl.feed_bit  = mag_reg[N-1];
        ctl.shift     = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    radix_next   = s_data.radix;
                    mag_next     = neg ? (~value_u + N'(1)) : value_u;
                    sign_next    = neg && (s_data.radix == DECIMAL);
                    started_next = 1'b0;
                    cnt_next     = '0;
                    ctl.clear    = 1'b1;
                    state_next   = radix_ok ? ST_CONV : ST_ERR;
                end
            end
            ST_CONV: begin
                ctl.act0 = (cnt_reg < N_CNT);
                mag_next = mag_reg << 1;
                cnt_next = cnt_reg + ONE_CNT;
                if (cnt_reg == CONV_LAST) begin
                    cnt_next   = N_CNT;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (sign_reg) begin
                    if (m_free) begin
                        m_valid_next = 1'b1;
                        m_data_next  = '{character: CHAR_MINUS, last_char: 1'b0,
                                         bad_radix: 1'b0};
                        sign_next    = 1'b0;
                    end
                end else if (skip) begin
                    ctl.shift = 1'b1;
                    cnt_next  = cnt_reg - ONE_CNT;
                end else if (m_free) begin
                    ctl.shift    = 1'b1;
                    cnt_next     = cnt_reg - ONE_CNT;
                    started_next = 1'b1;
                    m_valid_next = 1'b1;
                    m_data_next  = '{character: digit_char(top_digit),
                                     last_char: (cnt_reg == ONE_CNT), bad_radix: 1'b0};
                    if (cnt_reg == ONE_CNT) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_ERR: begin
                if (m_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '{character: CHAR_NONE, last_char: 1'b1, bad_radix: 1'b1};
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            sign_reg    <= 1'b0;
            started_reg <= 1'b0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            sign_reg    <= sign_next;
            started_reg <= started_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
        mag_reg    <= mag_next;
        radix_reg  <= radix_next;
        m_data_reg <= m_data_next;
    end

endmodule

### sv/itoa_digit_array.sv
// Row of radix digit cells: shift-double conversion with registered carries, then digit shift-out.
module itoa_digit_array
    import itoa_pkg::*;
#(
    parameter int MAX_RADIX = MAX_RADIX_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  digit_ctl_t                ctl,
    input  logic [RADIX_BITS-1:0]     radix,
    output logic [DIGIT_MAX_BITS-1:0] top_digit
);

    localparam int DW = $clog2(MAX_RADIX);
    localparam int N  = VALUE_BITS;

    logic [DW-1:0] digit_reg  [N];
    logic [DW-1:0] digit_next [N];
    logic [N-1:0]  carry_reg;
    logic [N-1:0]  carry_next;
    logic [N-1:0]  act_reg;
    logic [N-1:0]  cell_act;
    logic [N-1:0]  cell_cin;
    logic [6:0]    radix_w;

    assign radix_w   = 7'(radix);
    assign top_digit = DIGIT_MAX_BITS'(digit_reg[N-1]);

    for (genvar j = 0; j < N; j++) begin : g_cell
        logic [DW:0] dbl;
        logic [6:0]  dbl_w;

        if (j == 0) begin : g_first
            assign cell_act[j] = ctl.act0;
            assign cell_cin[j] = ctl.feed_bit;
        end else begin : g_rest
            assign cell_act[j] = act_reg[j-1];
            assign cell_cin[j] = carry_reg[j-1];
        end

        assign dbl   = {digit_reg[j], cell_cin[j]};
        assign dbl_w = 7'(dbl);

        always_comb begin
            digit_next[j] = digit_reg[j];
            carry_next[j] = 1'b0;
            if (ctl.clear) begin
                digit_next[j] = '0;
            end else if (ctl.shift) begin
                if (j == 0) begin
                    digit_next[j] = '0;
                end else begin
                    digit_next[j] = digit_reg[(j == 0) ? 0 : j-1];
                end
            end else if (cell_act[j]) begin
                if (dbl_w >= radix_w) begin
                    digit_next[j] = DW'(dbl_w - radix_w);
                    carry_next[j] = 1'b1;
                end else begin
                    digit_next[j] = DW'(dbl_w);
                end
            end
        end

        always_ff @(posedge aclk) begin
            digit_reg[j] <= digit_next[j];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            carry_reg <= '0;
            act_reg   <= '0;
        end else begin
            carry_reg <= carry_next;
            act_reg   <= ctl.clear ? '0 : cell_act;
        end
    end

endmodule

### sv/itoa_checker.sv
// Port-level assertions for the integer-to-ASCII converter, bound to the top level.
module itoa_checker
    import itoa_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      m_valid,
    input logic      m_ready,
    input out_word_t m_data
);

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result word valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result word changed");

    a_bad_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.bad_radix |-> m_data.last_char && (m_data.character == CHAR_NONE))
        else $error("bad radix word is not a lone empty word");

    a_minus_leads: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.character == CHAR_MINUS) |-> !m_data.last_char && !m_data.bad_radix)
        else $error("minus sign ends a run");

endmodule

bind int_to_ascii_radix itoa_checker u_itoa_checker (
    .aclk   (aclk),
    .aresetn(aresetn),
    .m_valid(m_valid),
    .m_ready(m_ready),
    .m_data (m_data)
);
